[src/value_noise_2d_cosine_top_assert.svh]
// assertion macros for the value noise top level
`ifndef VALUE_NOISE_2D_COSINE_TOP_ASSERT_SVH
`define VALUE_NOISE_2D_COSINE_TOP_ASSERT_SVH

// condition implies consequence a fixed number of cycles later
`define VN2C_ASSERT_AFTER(label, ante, cycles, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(cycles) (cons)) \
        else $error(msg);

// condition implies consequence on the next cycle
`define VN2C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/vn2c_pkg.sv]
// shared constants, types and weight table builder for the value noise block
package vn2c_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int WEIGHT_TABLE_DEPTH = 1024;
    localparam int OUT_FRAC_BITS      = 16;

    localparam int COORD_W     = 32;
    localparam int NOISE_W     = 18;
    localparam int WEIGHT_FRAC = 30;
    localparam int WEIGHT_W    = WEIGHT_FRAC + 1;
    localparam int IDX_W       = $clog2(WEIGHT_TABLE_DEPTH);
    localparam int HASH_W      = 31;
    localparam int CORNERS     = 4;
    localparam int SERIES_TERMS = 9;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t weight_table_t [WEIGHT_TABLE_DEPTH];
    typedef logic [CORNERS-1:0][HASH_W-1:0] corner_hash_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] ix;
        logic [COORD_W-1:0] iy;
        idx_t               jx;
        idx_t               jy;
    } split_beat_t;

    // sin^2 over a quarter turn, taylor series in horner form
    function automatic weight_table_t build_weight_table();
        weight_table_t   tbl;
        longint unsigned one;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned t;
        longint unsigned s;
        one = 64'd1 << WEIGHT_FRAC;
        for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++)
        begin
            a  = (64'(i) * HALF_PI_Q30) / WEIGHT_TABLE_DEPTH;
            a2 = (a * a) >> WEIGHT_FRAC;
            t  = one;
            for (int k = SERIES_TERMS; k >= 1; k--)
            begin
                t = one - (((a2 * t) >> WEIGHT_FRAC) / 64'((2 * k) * (2 * k + 1)));
            end
            s = (a * t) >> WEIGHT_FRAC;
            tbl[i] = WEIGHT_W'((s * s) >> WEIGHT_FRAC);
        end
        return tbl;
    endfunction

endpackage

[src/vn2c_split.sv]
// coordinate split into lattice integer parts and weight table indexes
module vn2c_split (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [vn2c_pkg::COORD_W-1:0] x_coord,
    input  logic signed [vn2c_pkg::COORD_W-1:0] y_coord,
    output vn2c_pkg::split_beat_t               beat
);
    import vn2c_pkg::*;

    localparam int SCALE_W = FRAC_BITS + $clog2(WEIGHT_TABLE_DEPTH + 1);

    function automatic idx_t frac_index(logic [COORD_W-1:0] mag);
        logic [SCALE_W-1:0] scaled;
        scaled = (SCALE_W'(mag[FRAC_BITS-1:0]) * SCALE_W'(WEIGHT_TABLE_DEPTH)) >> FRAC_BITS;
        if (scaled >= SCALE_W'(WEIGHT_TABLE_DEPTH))
        begin
            scaled = SCALE_W'(WEIGHT_TABLE_DEPTH - 1);
        end
        return IDX_W'(scaled);
    endfunction

    function automatic logic [COORD_W-1:0] int_part(logic [COORD_W-1:0] mag, logic neg);
        logic [COORD_W-1:0] ip;
        ip = mag >> FRAC_BITS;
        return neg ? (COORD_W'(0) - ip) : ip;
    endfunction

    logic               valid_a_reg;
    logic [COORD_W-1:0] x_mag_reg;
    logic [COORD_W-1:0] y_mag_reg;
    logic               x_neg_reg;
    logic               y_neg_reg;
    logic [COORD_W-1:0] x_mag_next;
    logic [COORD_W-1:0] y_mag_next;

    logic               valid_b_reg;
    logic [COORD_W-1:0] ix_reg;
    logic [COORD_W-1:0] iy_reg;
    idx_t               jx_reg;
    idx_t               jy_reg;

    assign x_mag_next = x_coord[COORD_W-1] ? (COORD_W'(0) - x_coord) : x_coord;
    assign y_mag_next = y_coord[COORD_W-1] ? (COORD_W'(0) - y_coord) : y_coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= start;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_mag_reg <= x_mag_next;
        y_mag_reg <= y_mag_next;
        x_neg_reg <= x_coord[COORD_W-1];
        y_neg_reg <= y_coord[COORD_W-1];
        ix_reg    <= int_part(x_mag_reg, x_neg_reg);
        iy_reg    <= int_part(y_mag_reg, y_neg_reg);
        jx_reg    <= frac_index(x_mag_reg);
        jy_reg    <= frac_index(y_mag_reg);
    end

    assign beat = '{valid: valid_b_reg, ix: ix_reg, iy: iy_reg, jx: jx_reg, jy: jy_reg};

endmodule

[src/vn2c_weight_rom.sv]
// cosine blend weight rom, two registered read ports
module vn2c_weight_rom (
    input  logic              clk,
    input  vn2c_pkg::idx_t    jx,
    input  vn2c_pkg::idx_t    jy,
    output vn2c_pkg::weight_t wx,
    output vn2c_pkg::weight_t wy
);
    import vn2c_pkg::*;

    localparam weight_table_t WEIGHT_ROM = build_weight_table();

    weight_t wx_reg;
    weight_t wy_reg;

    always_ff @(posedge clk)
    begin
        wx_reg <= WEIGHT_ROM[jx];
        wy_reg <= WEIGHT_ROM[jy];
    end

    assign wx = wx_reg;
    assign wy = wy_reg;

endmodule

[src/vn2c_hash.sv]
// four-lane lattice corner hash pipeline
module vn2c_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  logic [vn2c_pkg::COORD_W-1:0] ix,
    input  logic [vn2c_pkg::COORD_W-1:0] iy,
    input  logic [vn2c_pkg::COORD_W-1:0] seed,
    output logic                         valid_out,
    output vn2c_pkg::corner_hash_t       hash
);
    import vn2c_pkg::*;

    localparam logic [COORD_W-1:0] ROW_MUL   = 32'd57;
    localparam int                 XOR_SHIFT = 13;
    localparam logic [COORD_W-1:0] SQ_MUL    = 32'd60493;
    localparam logic [COORD_W-1:0] SQ_ADD    = 32'd19990303;
    localparam logic [COORD_W-1:0] FIN_ADD   = 32'd1376312589;
    localparam int                 STAGES    = 5;

    typedef logic [COORD_W-1:0] word_t;

    logic [STAGES-1:0] valid_reg;

    word_t ix_c_reg;
    word_t row_c_reg;
    word_t row_c_next;

    word_t n_d_reg  [CORNERS];
    word_t n_d_next [CORNERS];
    word_t n_e_reg  [CORNERS];
    word_t sq_e_reg [CORNERS];
    word_t n_f_reg  [CORNERS];
    word_t m_f_reg  [CORNERS];
    corner_hash_t hash_reg;

    assign row_c_next = (iy - seed) * ROW_MUL + seed;

    always_comb
    begin
        word_t n;
        word_t cy_off;
        for (int c = 0; c < CORNERS; c++)
        begin
            cy_off = ((c & 2) != 0) ? ROW_MUL : '0;
            n = ix_c_reg + COORD_W'(c & 1) + row_c_reg + cy_off;
            n_d_next[c] = n ^ (n << XOR_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        ix_c_reg  <= ix;
        row_c_reg <= row_c_next;
        for (int c = 0; c < CORNERS; c++)
        begin
            n_d_reg[c]  <= n_d_next[c];
            n_e_reg[c]  <= n_d_reg[c];
            sq_e_reg[c] <= n_d_reg[c] * n_d_reg[c];
            n_f_reg[c]  <= n_e_reg[c];
            m_f_reg[c]  <= sq_e_reg[c] * SQ_MUL + SQ_ADD;
            hash_reg[c] <= HASH_W'(n_f_reg[c] * m_f_reg[c] + FIN_ADD);
        end
    end

    assign valid_out = valid_reg[STAGES-1];
    assign hash      = hash_reg;

endmodule

[src/vn2c_blend.sv]
// cosine blend along x then y and output rounding
module vn2c_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  vn2c_pkg::corner_hash_t              hash,
    input  vn2c_pkg::weight_t                   wx,
    input  vn2c_pkg::weight_t                   wy,
    output logic                                valid_out,
    output logic signed [vn2c_pkg::NOISE_W-1:0] noise_value
);
    import vn2c_pkg::*;

    localparam int STAGES    = 7;
    localparam int PROD_W    = 64;
    localparam int VAL_W     = 32;
    localparam int OUT_SHIFT = WEIGHT_FRAC - OUT_FRAC_BITS;

    localparam logic [VAL_W-1:0]         ONE_Q    = VAL_W'(1) << WEIGHT_FRAC;
    localparam logic signed [PROD_W-1:0] HALF_W   = PROD_W'(1) << (WEIGHT_FRAC - 1);
    localparam logic signed [VAL_W:0]    HALF_OUT =
        (OUT_SHIFT == 0) ? '0 : ((VAL_W + 1)'(1) << (OUT_SHIFT - 1));

    logic [STAGES-1:0] valid_reg;

    logic signed [VAL_W-1:0] s_h_reg, d0_h_reg, u_h_reg, d1_h_reg;
    logic signed [VAL_W-1:0] s_h_next, d0_h_next, u_h_next, d1_h_next;
    weight_t                 wx_h_reg, wy_h_reg;

    logic signed [VAL_W-1:0]  s_i_reg, u_i_reg;
    logic signed [PROD_W-1:0] p0_i_reg, p1_i_reg, p0_i_next, p1_i_next;
    weight_t                  wy_i_reg;

    logic signed [VAL_W-1:0] r0_j_reg, r1_j_reg, r0_j_next, r1_j_next;
    weight_t                 wy_j_reg;

    logic signed [VAL_W-1:0] r0_k_reg;
    logic signed [VAL_W:0]   dy_k_reg, dy_k_next;
    weight_t                 wy_k_reg;

    logic signed [VAL_W-1:0]  r0_l_reg;
    logic signed [PROD_W-1:0] py_l_reg, py_l_next;

    logic signed [VAL_W-1:0] r_m_reg, r_m_next;

    logic signed [VAL_W:0]   rounded;
    logic signed [NOISE_W-1:0] noise_reg, noise_next;

    assign s_h_next  = ONE_Q - VAL_W'(hash[0]);
    assign d0_h_next = VAL_W'(hash[0]) - VAL_W'(hash[1]);
    assign u_h_next  = ONE_Q - VAL_W'(hash[2]);
    assign d1_h_next = VAL_W'(hash[2]) - VAL_W'(hash[3]);

    assign p0_i_next = d0_h_reg * $signed({1'b0, wx_h_reg});
    assign p1_i_next = d1_h_reg * $signed({1'b0, wx_h_reg});

    assign r0_j_next = s_i_reg + VAL_W'((p0_i_reg + HALF_W) >>> WEIGHT_FRAC);
    assign r1_j_next = u_i_reg + VAL_W'((p1_i_reg + HALF_W) >>> WEIGHT_FRAC);

    assign dy_k_next = r1_j_reg - r0_j_reg;

    assign py_l_next = dy_k_reg * $signed({1'b0, wy_k_reg});

    assign r_m_next = r0_l_reg + VAL_W'((py_l_reg + HALF_W) >>> WEIGHT_FRAC);

    assign rounded    = ((VAL_W + 1)'(r_m_reg) + HALF_OUT) >>> OUT_SHIFT;
    assign noise_next = NOISE_W'(rounded);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        s_h_reg   <= s_h_next;
        d0_h_reg  <= d0_h_next;
        u_h_reg   <= u_h_next;
        d1_h_reg  <= d1_h_next;
        wx_h_reg  <= wx;
        wy_h_reg  <= wy;

        s_i_reg   <= s_h_reg;
        u_i_reg   <= u_h_reg;
        p0_i_reg  <= p0_i_next;
        p1_i_reg  <= p1_i_next;
        wy_i_reg  <= wy_h_reg;

        r0_j_reg  <= r0_j_next;
        r1_j_reg  <= r1_j_next;
        wy_j_reg  <= wy_i_reg;

        r0_k_reg  <= r0_j_reg;
        dy_k_reg  <= dy_k_next;
        wy_k_reg  <= wy_j_reg;

        r0_l_reg  <= r0_k_reg;
        py_l_reg  <= py_l_next;

        r_m_reg   <= r_m_next;

        noise_reg <= noise_next;
    end

    assign valid_out   = valid_reg[STAGES-1];
    assign noise_value = noise_reg;

endmodule

[src/value_noise_2d_cosine_top.sv]
// top level of the 2d cosine-interpolated value noise pipeline
//
// usage
//   input: a point (x_coord, y_coord) in signed q16.16 is taken at each rising
//   edge with start high and busy low; busy stays low, so one point can enter
//   every cycle.
//   output: done is high for exactly one cycle with noise_value (signed q1.16)
//   valid; results leave in input order. throughput is one point per cycle.
//   stages: split (2), corner hash multiply chain (5), blend (7).
//   seed: written with seed_wr_en and seed_wr_data; the user must write it only
//   while no beat is in flight, which the block does not enforce; it takes
//   effect for points taken after the write.
//   reset: rst_n low clears the seed to zero and all stage valid bits, so no
//   done pulse follows for points taken before reset.
//   the receiver cannot stall: each result beat is shown for one cycle only.
`include "value_noise_2d_cosine_top_assert.svh"

module value_noise_2d_cosine_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [vn2c_pkg::COORD_W-1:0] x_coord,
    input  logic signed [vn2c_pkg::COORD_W-1:0] y_coord,
    input  logic                                seed_wr_en,
    input  logic signed [vn2c_pkg::COORD_W-1:0] seed_wr_data,
    output logic                                done,
    output logic signed [vn2c_pkg::NOISE_W-1:0] noise_value
);
    import vn2c_pkg::*;

    localparam int W_DELAY      = 4;
    localparam int HASH_LATENCY = 5;
    localparam int LATENCY      = 14;

    logic [COORD_W-1:0] seed_reg;
    split_beat_t        beat;
    weight_t            wx_rom;
    weight_t            wy_rom;
    weight_t            wx_dly_reg [W_DELAY];
    weight_t            wy_dly_reg [W_DELAY];
    logic               hash_valid;
    corner_hash_t       hash;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr_en)
        begin
            seed_reg <= seed_wr_data;
        end
    end

    vn2c_split u_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start && !busy),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .beat    (beat)
    );

    vn2c_weight_rom u_weight_rom (
        .clk (clk),
        .jx  (beat.jx),
        .jy  (beat.jy),
        .wx  (wx_rom),
        .wy  (wy_rom)
    );

    vn2c_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (beat.valid),
        .ix        (beat.ix),
        .iy        (beat.iy),
        .seed      (seed_reg),
        .valid_out (hash_valid),
        .hash      (hash)
    );

    // align weights with the hash output
    always_ff @(posedge clk)
    begin
        wx_dly_reg[0] <= wx_rom;
        wy_dly_reg[0] <= wy_rom;
        for (int i = 1; i < W_DELAY; i++)
        begin
            wx_dly_reg[i] <= wx_dly_reg[i-1];
            wy_dly_reg[i] <= wy_dly_reg[i-1];
        end
    end

    vn2c_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (hash_valid),
        .hash        (hash),
        .wx          (wx_dly_reg[W_DELAY-1]),
        .wy          (wy_dly_reg[W_DELAY-1]),
        .valid_out   (done),
        .noise_value (noise_value)
    );

    `VN2C_ASSERT_AFTER(a_beat_gives_done, start && !busy, LATENCY, done, "accepted beat lost")
    `VN2C_ASSERT_AFTER(a_no_beat_no_done, !start, LATENCY, !done, "result without input beat")
    `VN2C_ASSERT_AFTER(a_hash_aligned, beat.valid, HASH_LATENCY, hash_valid, "hash lane misaligned")
    `VN2C_ASSERT_NEXT(a_seed_write, seed_wr_en, seed_reg == $past(seed_wr_data), "seed not written")

endmodule
